// File: design/bdaq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdaq_pkg: shared types and codes of the button debounce / auto-repeat queue
// Button and event codes, operation codes, register indexes and the structs
// that travel between the tracker, the event queue and the top level.
// ----------------------------------------------------------------------------
package bdaq_pkg;

   localparam int BTN_W   = 3;
   localparam int EV_W    = 3;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Button codes after the priority encoder
   localparam logic [BTN_W-1:0] BTN_SEL    = 3'd0;
   localparam logic [BTN_W-1:0] BTN_UP     = 3'd1;
   localparam logic [BTN_W-1:0] BTN_DN     = 3'd2;
   localparam logic [BTN_W-1:0] BTN_LEFT   = 3'd3;
   localparam logic [BTN_W-1:0] BTN_NONE   = 3'd4;

   // Event codes on the result channel
   localparam logic [EV_W-1:0] EV_NONE = 3'd0;

   // Operation codes
   localparam logic OP_POLL  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT   = 2'd2;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;
   localparam logic [CFG_W-1:0] REPEAT_RESET   = 16'd100;

   typedef struct packed {
      logic [CFG_W-1:0] dbnc_ms;
      logic [CFG_W-1:0] hold_ms;
      logic [CFG_W-1:0] repeat_ms;
   } cfg_type;

   typedef struct packed {
      logic            valid;
      logic [EV_W-1:0] ev;
   } push_type;

endpackage

// File: design/bdaq_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdaq_tracker: button debounce and hold / auto-repeat tracker
// Picks one pressed button by priority, applies the debounce, hold and repeat
// timing, and offers at most one event per poll to the event queue.
// ----------------------------------------------------------------------------
module bdaq_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           select_n,
   input  logic                           up_n,
   input  logic                           down_n,
   input  logic                           left_n,
   input  logic [bdaq_pkg::TIME_W-1:0]    now_ms,
   input  bdaq_pkg::cfg_type              cfg,
   output bdaq_pkg::push_type             push
);

   logic [bdaq_pkg::BTN_W-1:0]  last_button_ff, last_button_in;
   logic [bdaq_pkg::TIME_W-1:0] last_press_ff, last_press_in;
   logic [bdaq_pkg::TIME_W-1:0] press_start_ff, press_start_in;
   logic                        holding_ff, holding_in;

   logic [bdaq_pkg::BTN_W-1:0]  btn;
   logic [bdaq_pkg::TIME_W-1:0] since_last;
   logic [bdaq_pkg::TIME_W-1:0] since_start;
   logic                        hold_now;

   always_comb begin
      if (!select_n) begin
         btn = bdaq_pkg::BTN_SEL;
      end else if (!up_n) begin
         btn = bdaq_pkg::BTN_UP;
      end else if (!down_n) begin
         btn = bdaq_pkg::BTN_DN;
      end else if (!left_n) begin
         btn = bdaq_pkg::BTN_LEFT;
      end else begin
         btn = bdaq_pkg::BTN_NONE;
      end
   end

   // wrapping differences
   assign since_last  = now_ms - last_press_ff;
   assign since_start = now_ms - press_start_ff;
   assign hold_now    = holding_ff ||
                        (since_start > {16'd0, cfg.hold_ms});

   always_comb begin
      last_button_in = last_button_ff;
      last_press_in  = last_press_ff;
      press_start_in = press_start_ff;
      holding_in     = holding_ff;
      push.valid     = 1'b0;
      push.ev        = btn + 3'd1;
      if (btn == bdaq_pkg::BTN_NONE) begin
         last_button_in = bdaq_pkg::BTN_NONE;
         holding_in     = 1'b0;
      end else if (last_button_ff != btn) begin
         if (since_last > {16'd0, cfg.dbnc_ms}) begin
            last_press_in  = now_ms;
            press_start_in = now_ms;
            last_button_in = btn;
            holding_in     = 1'b0;
            push.valid     = 1'b1;
         end
      end else begin
         holding_in = hold_now;
         if (hold_now && (since_last > {16'd0, cfg.repeat_ms})) begin
            last_press_in = now_ms;
            // only up and down repeat
            push.valid    = (btn inside {bdaq_pkg::BTN_UP, bdaq_pkg::BTN_DN});
         end
      end
      if (!step) begin
         push.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_button_ff <= bdaq_pkg::BTN_NONE;
         last_press_ff  <= '0;
         press_start_ff <= '0;
         holding_ff     <= 1'b0;
      end else if (step) begin
         last_button_ff <= last_button_in;
         last_press_ff  <= last_press_in;
         press_start_ff <= press_start_in;
         holding_ff     <= holding_in;
      end
   end

endmodule

// File: design/bdaq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdaq_queue: drop-on-full event queue
// Circular buffer of events; per step at most one push, then one pop. A push
// into an empty queue comes straight out on the same step.
// ----------------------------------------------------------------------------
module bdaq_queue #(
   parameter int QUEUE_DEPTH = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        clear,
   input  bdaq_pkg::push_type          push,
   output logic [bdaq_pkg::EV_W-1:0]   pop_ev
);

   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [bdaq_pkg::EV_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [HW-1:0]             head_ff, head_in;
   logic [CW-1:0]             count_ff, count_in;

   logic [SW-1:0]             tail_sum;
   logic [SW-1:0]             tail_wrap;
   logic [HW-1:0]             tail;
   logic [HW-1:0]             head_next;
   logic                      do_push;
   logic                      do_pop;

   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? (tail_sum - SW'(QUEUE_DEPTH)) : tail_sum;
   assign tail      = tail_wrap[HW-1:0];
   assign head_next = (head_ff == HW'(QUEUE_DEPTH - 1)) ? '0 : (head_ff + HW'(1));

   assign do_push = push.valid && (count_ff < CW'(QUEUE_DEPTH));
   assign do_pop  = (count_ff != '0) || do_push;

   always_comb begin
      if (clear) begin
         pop_ev = bdaq_pkg::EV_NONE;
      end else if (count_ff != '0) begin
         pop_ev = entry_ff[head_ff];
      end else if (do_push) begin
         // bypass the fresh event
         pop_ev = push.ev;
      end else begin
         pop_ev = bdaq_pkg::EV_NONE;
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (clear) begin
         head_in  = '0;
         count_in = '0;
      end else begin
         if (do_pop) begin
            head_in = head_next;
         end
         if (do_push && !do_pop) begin
            count_in = count_ff + CW'(1);
         end else if (!do_push && do_pop) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && !clear && do_push) begin
         entry_ff[tail] <= push.ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: design/button_debounce_autorepeat_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_queue: debounced buttons with auto-repeat queue
// Polls four active-low buttons with a millisecond timestamp, turns debounced
// presses and up/down auto-repeat into events, and pops at most one event per poll.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+--------------------------------------
//   req_    | in  | req_valid/req_stall  | op, select_n, up_n, down_n, left_n,
//           |     |                      | now_ms
//   rsp_    | out | rsp_valid/rsp_stall  | event_res
//   csr_    | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A word taken sits in the input register, then moves into the result register,
// which offers it on the result channel: one word per cycle while no stall holds it.
// Tracker and queue state update as the result loads, so each word sees the
// state its predecessor left. Reset restores tracker, queue pointers and
// registers to their defaults; queue entries are not cleared. A stalled full
// result holds the input register, and the request side stalls only then.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_queue #(
   parameter int QUEUE_DEPTH = 5
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic                              req_select_n,
   input  logic                              req_up_n,
   input  logic                              req_down_n,
   input  logic                              req_left_n,
   input  logic [bdaq_pkg::TIME_W-1:0]       req_now_ms,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bdaq_pkg::EV_W-1:0]         rsp_event_res,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bdaq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdaq_pkg::CFG_W-1:0]        csr_wdata
);

   // configuration registers
   bdaq_pkg::cfg_type cfg_ff;

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic                        in_op_ff;
   logic                        in_select_n_ff;
   logic                        in_up_n_ff;
   logic                        in_down_n_ff;
   logic                        in_left_n_ff;
   logic [bdaq_pkg::TIME_W-1:0] in_now_ff;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bdaq_pkg::EV_W-1:0]   rsp_event_ff;

   logic                        out_free;
   logic                        advance;
   logic                        req_take;
   logic                        poll_step;
   bdaq_pkg::push_type          push;
   logic [bdaq_pkg::EV_W-1:0]   pop_ev;

   // writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dbnc_ms     <= bdaq_pkg::DEBOUNCE_RESET;
         cfg_ff.hold_ms     <= bdaq_pkg::HOLD_RESET;
         cfg_ff.repeat_ms   <= bdaq_pkg::REPEAT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdaq_pkg::CSR_DEBOUNCE: cfg_ff.dbnc_ms     <= csr_wdata;
            bdaq_pkg::CSR_HOLD:     cfg_ff.hold_ms     <= csr_wdata;
            bdaq_pkg::CSR_REPEAT:   cfg_ff.repeat_ms   <= csr_wdata;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // Advance the input word whenever the result slot is empty or draining.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign poll_step = advance && (in_op_ff == bdaq_pkg::OP_POLL);

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff       <= req_op;
         in_select_n_ff <= req_select_n;
         in_up_n_ff     <= req_up_n;
         in_down_n_ff   <= req_down_n;
         in_left_n_ff   <= req_left_n;
         in_now_ff      <= req_now_ms;
      end
   end

   // Track presses, holds and repeats; a clear word leaves this state alone.
   bdaq_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .step     (poll_step),
      .select_n (in_select_n_ff),
      .up_n     (in_up_n_ff),
      .down_n   (in_down_n_ff),
      .left_n   (in_left_n_ff),
      .now_ms   (in_now_ff),
      .cfg      (cfg_ff),
      .push     (push)
   );

   // Push then pop one event per poll; a clear word empties the queue.
   bdaq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .clear  (in_op_ff == bdaq_pkg::OP_CLEAR),
      .push   (push),
      .pop_ev (pop_ev)
   );

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= pop_ev;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;

endmodule
